// ===== src/swtq_pkg.sv =====
package swtq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int ID_BITS     = 10;
	localparam int SEC_W       = 32;
	localparam int USEC_W      = 20;
	localparam int TIME_W      = 52;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [USEC_W-1:0] US_PER_SEC = USEC_W'(1000000);

	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic [SEC_W-1:0]   sec;
		logic [USEC_W-1:0]  usec;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_POP    = 2'd1,
		ACT_REMOVE = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_ADD   = 7'b0000010,
		S_PLACE = 7'b0000100,
		S_FIND  = 7'b0001000,
		S_DROP  = 7'b0010000,
		S_HREAD = 7'b0100000,
		S_HOUT  = 7'b1000000
	} state_t;

endpackage

// ===== src/sorted_wakeup_timer_queue.sv =====
// Channel   Handshake        Fields
// command   start / busy     action, entry_id, wake_sec, wake_usec
// result    done (strobe)    status, head_valid, head_id, head_sec, head_usec,
//                            head_time_us, entry_count
//
// One item at a time; busy stays high from accept until the cycle of done.
// Add walks back from the tail one entry per cycle, shifting up the entries at
// or after the insert point. Pop and remove shift down one entry per cycle;
// remove first scans from the head for the matching id.
// The single-port-pair entry RAM (one read, one write per cycle) sets this pace.
// Reset clears the state, fill count, index and done; the RAM needs no clearing. done cannot be stalled.
module sorted_wakeup_timer_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   action,
	input  logic [swtq_pkg::ID_BITS-1:0] entry_id,
	input  logic [swtq_pkg::SEC_W-1:0]   wake_sec,
	input  logic [swtq_pkg::USEC_W-1:0]  wake_usec,
	output logic                         done,
	output logic [1:0]                   status,
	output logic                         head_valid,
	output logic [swtq_pkg::ID_BITS-1:0] head_id,
	output logic [swtq_pkg::SEC_W-1:0]   head_sec,
	output logic [swtq_pkg::USEC_W-1:0]  head_usec,
	output logic [swtq_pkg::TIME_W-1:0]  head_time_us,
	output logic [swtq_pkg::CNT_W-1:0]   entry_count
);

	swtq_pkg::state_t                state_q;
	logic [swtq_pkg::CNT_W-1:0]      fill_q;
	logic [swtq_pkg::CNT_W-1:0]      idx_q;
	logic                            pend_s1;
	logic [swtq_pkg::CNT_W-1:0]      rd_idx_s1;
	logic [1:0]                      act_q;
	swtq_pkg::entry_t                cmd_q;
	logic [1:0]                      stat_q;
	logic                            done_q;
	logic                            hvalid_q;
	swtq_pkg::entry_t                head_q;
	logic [swtq_pkg::TIME_W-1:0]     htime_q;

	logic                            accept;
	logic [swtq_pkg::CNT_W-1:0]      fill_last;
	swtq_pkg::entry_t                rd_data;
	logic                            ram_we;
	logic [swtq_pkg::IDX_W-1:0]      ram_waddr;
	swtq_pkg::entry_t                ram_wdata;
	logic [swtq_pkg::IDX_W-1:0]      ram_raddr;
	logic                            ge_hit;
	logic                            id_hit;
	logic                            scanning;
	logic [swtq_pkg::TIME_W-1:0]     head_time_d;

	assign busy      = (state_q != swtq_pkg::S_IDLE);
	assign accept    = start && !busy;
	assign fill_last = fill_q - swtq_pkg::CNT_W'(1);

	// stored entry at or later than the new wake time
	assign ge_hit = (rd_data.sec != cmd_q.sec) ? (rd_data.sec > cmd_q.sec)
	                                           : (rd_data.usec >= cmd_q.usec);
	assign id_hit = (rd_data.id == cmd_q.id);

	assign scanning = (state_q == swtq_pkg::S_ADD) || (state_q == swtq_pkg::S_FIND)
	               || (state_q == swtq_pkg::S_DROP);

	swtq_ram #(
		.WIDTH(swtq_pkg::ENTRY_W),
		.DEPTH(swtq_pkg::QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	// drive RAM ports: shift moves, new-entry placement, head read
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = rd_data;
		ram_raddr = idx_q[swtq_pkg::IDX_W-1:0];
		case (state_q)
			swtq_pkg::S_ADD: begin
				if (pend_s1 && ge_hit) begin
					ram_we    = 1'b1;
					ram_waddr = swtq_pkg::IDX_W'(rd_idx_s1 + swtq_pkg::CNT_W'(1));
				end
			end
			swtq_pkg::S_PLACE: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q[swtq_pkg::IDX_W-1:0];
				ram_wdata = cmd_q;
			end
			swtq_pkg::S_DROP: begin
				if (pend_s1) begin
					ram_we    = 1'b1;
					ram_waddr = swtq_pkg::IDX_W'(rd_idx_s1 - swtq_pkg::CNT_W'(1));
				end
			end
			swtq_pkg::S_HREAD: begin
				ram_raddr = '0;
			end
			default: begin
			end
		endcase
	end

	// head time in microseconds, masked to the output width
	assign head_time_d = swtq_pkg::TIME_W'(rd_data.sec) * swtq_pkg::TIME_W'(swtq_pkg::US_PER_SEC)
	                   + swtq_pkg::TIME_W'(rd_data.usec);

	// sequence one item: scan, shift, place, then read the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swtq_pkg::S_IDLE;
			fill_q  <= '0;
			idx_q   <= '0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				swtq_pkg::S_IDLE: begin
					pend_s1 <= 1'b0;
					if (accept) begin
						case (action)
							swtq_pkg::ACT_ADD: begin
								if (fill_q == swtq_pkg::CNT_W'(swtq_pkg::QUEUE_DEPTH)) begin
									state_q <= swtq_pkg::S_HREAD;
								end else if (fill_q == '0) begin
									idx_q   <= '0;
									state_q <= swtq_pkg::S_PLACE;
								end else begin
									idx_q   <= fill_last;
									state_q <= swtq_pkg::S_ADD;
								end
							end
							swtq_pkg::ACT_POP: begin
								if (fill_q == '0) begin
									state_q <= swtq_pkg::S_HREAD;
								end else if (fill_last == '0) begin
									fill_q  <= fill_last;
									state_q <= swtq_pkg::S_HREAD;
								end else begin
									idx_q   <= swtq_pkg::CNT_W'(1);
									state_q <= swtq_pkg::S_DROP;
								end
							end
							swtq_pkg::ACT_REMOVE: begin
								if (fill_q == '0) begin
									state_q <= swtq_pkg::S_HREAD;
								end else begin
									idx_q   <= '0;
									state_q <= swtq_pkg::S_FIND;
								end
							end
							default: begin
								state_q <= swtq_pkg::S_HREAD;
							end
						endcase
					end
				end
				swtq_pkg::S_ADD: begin
					// walk down from the tail, shifting later entries up
					idx_q   <= idx_q - swtq_pkg::CNT_W'(1);
					pend_s1 <= 1'b1;
					if (pend_s1) begin
						if (ge_hit) begin
							if (rd_idx_s1 == '0) begin
								idx_q   <= '0;
								state_q <= swtq_pkg::S_PLACE;
							end
						end else begin
							idx_q   <= rd_idx_s1 + swtq_pkg::CNT_W'(1);
							state_q <= swtq_pkg::S_PLACE;
						end
					end
				end
				swtq_pkg::S_PLACE: begin
					fill_q  <= fill_q + swtq_pkg::CNT_W'(1);
					state_q <= swtq_pkg::S_HREAD;
				end
				swtq_pkg::S_FIND: begin
					// scan from the head for a matching id
					idx_q   <= idx_q + swtq_pkg::CNT_W'(1);
					pend_s1 <= 1'b1;
					if (pend_s1) begin
						if (id_hit) begin
							if (rd_idx_s1 == fill_last) begin
								fill_q  <= fill_last;
								state_q <= swtq_pkg::S_HREAD;
							end else begin
								idx_q   <= rd_idx_s1 + swtq_pkg::CNT_W'(1);
								pend_s1 <= 1'b0;
								state_q <= swtq_pkg::S_DROP;
							end
						end else if (rd_idx_s1 == fill_last) begin
							state_q <= swtq_pkg::S_HREAD;
						end
					end
				end
				swtq_pkg::S_DROP: begin
					// shift later entries down over the removed slot
					idx_q   <= idx_q + swtq_pkg::CNT_W'(1);
					pend_s1 <= 1'b1;
					if (pend_s1 && (rd_idx_s1 == fill_last)) begin
						fill_q  <= fill_last;
						state_q <= swtq_pkg::S_HREAD;
					end
				end
				swtq_pkg::S_HREAD: begin
					state_q <= swtq_pkg::S_HOUT;
				end
				swtq_pkg::S_HOUT: begin
					done_q  <= 1'b1;
					state_q <= swtq_pkg::S_IDLE;
				end
				default: begin
					state_q <= swtq_pkg::S_IDLE;
				end
			endcase
		end
	end

	// hold the item, status and result payload
	always_ff @(posedge clk) begin
		if (scanning) begin
			rd_idx_s1 <= idx_q;
		end
		if (accept) begin
			act_q     <= action;
			cmd_q.id  <= entry_id;
			cmd_q.sec <= wake_sec;
			cmd_q.usec <= wake_usec;
			stat_q    <= swtq_pkg::ST_DONE;
			case (action)
				swtq_pkg::ACT_ADD: begin
					if (fill_q == swtq_pkg::CNT_W'(swtq_pkg::QUEUE_DEPTH)) begin
						stat_q <= swtq_pkg::ST_FULL;
					end
				end
				swtq_pkg::ACT_POP: begin
					if (fill_q == '0) begin
						stat_q <= swtq_pkg::ST_EMPTY;
					end
				end
				swtq_pkg::ACT_REMOVE: begin
					if (fill_q == '0) begin
						stat_q <= swtq_pkg::ST_NOTFOUND;
					end
				end
				default: begin
				end
			endcase
		end
		if ((state_q == swtq_pkg::S_FIND) && pend_s1 && !id_hit && (rd_idx_s1 == fill_last)
		    && (act_q == swtq_pkg::ACT_REMOVE)) begin
			stat_q <= swtq_pkg::ST_NOTFOUND;
		end
		if (state_q == swtq_pkg::S_HOUT) begin
			if (fill_q != '0) begin
				hvalid_q <= 1'b1;
				head_q   <= rd_data;
				htime_q  <= head_time_d;
			end else begin
				hvalid_q <= 1'b0;
				head_q   <= '0;
				htime_q  <= '0;
			end
		end
	end

	assign done         = done_q;
	assign status       = stat_q;
	assign head_valid   = hvalid_q;
	assign head_id      = head_q.id;
	assign head_sec     = head_q.sec;
	assign head_usec    = head_q.usec;
	assign head_time_us = htime_q;
	assign entry_count  = fill_q;

endmodule

// ===== src/swtq_ram.sv =====
module swtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write one port, read the other into a register
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sim/wakeup_queue_checker.sv =====
module wakeup_queue_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [1:0]                    action,
	input  logic [swtq_pkg::ID_BITS-1:0]  entry_id,
	input  logic [swtq_pkg::SEC_W-1:0]    wake_sec,
	input  logic [swtq_pkg::USEC_W-1:0]   wake_usec,
	input  logic                          done,
	input  logic [1:0]                    status,
	input  logic                          head_valid,
	input  logic [swtq_pkg::ID_BITS-1:0]  head_id,
	input  logic [swtq_pkg::SEC_W-1:0]    head_sec,
	input  logic [swtq_pkg::USEC_W-1:0]   head_usec,
	input  logic [swtq_pkg::TIME_W-1:0]   head_time_us,
	input  logic [swtq_pkg::CNT_W-1:0]    entry_count,
	output int                            fail_count,
	output int                            waiting
);

	localparam longint unsigned USEC_PER_SEC = 1000000;

	typedef struct packed {
		swtq_pkg::status_t                  status;
		logic                               head_valid;
		logic [swtq_pkg::ID_BITS-1:0]       head_id;
		logic [swtq_pkg::SEC_W-1:0]         head_sec;
		logic [swtq_pkg::USEC_W-1:0]        head_usec;
		logic [swtq_pkg::TIME_W-1:0]        head_time_us;
		logic [swtq_pkg::CNT_W-1:0]         entry_count;
	} head_report_t;

	// sleeping entries in wake order, and the reports still owed by the block
	swtq_pkg::entry_t sleepers[$];
	head_report_t     due_reports[$];
	int               mismatches = 0;

	assign fail_count = mismatches;

	task automatic log_mismatch(string msg);
		$display("%0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			log_mismatch($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
	endtask

	// apply one action to the sleeper list and build the head report it yields
	function automatic head_report_t apply_action(logic [1:0] act,
			logic [swtq_pkg::ID_BITS-1:0] id, logic [swtq_pkg::SEC_W-1:0] sec,
			logic [swtq_pkg::USEC_W-1:0] usec);
		head_report_t     rep;
		swtq_pkg::entry_t fresh;
		int               pos;
		rep = '0;
		rep.status = swtq_pkg::ST_DONE;
		case (act)
		swtq_pkg::ACT_ADD: begin
			if (sleepers.size() >= swtq_pkg::QUEUE_DEPTH) begin
				rep.status = swtq_pkg::ST_FULL;
			end else begin
				// go ahead of the first entry due at the same time or later
				pos = sleepers.size();
				for (int i = 0; i < sleepers.size(); i++) begin
					if (pos == sleepers.size() && (sleepers[i].sec > sec ||
							(sleepers[i].sec == sec && sleepers[i].usec >= usec)))
						pos = i;
				end
				fresh.id = id;
				fresh.sec = sec;
				fresh.usec = usec;
				sleepers.insert(pos, fresh);
			end
		end
		swtq_pkg::ACT_POP: begin
			if (sleepers.size() == 0)
				rep.status = swtq_pkg::ST_EMPTY;
			else
				sleepers.delete(0);
		end
		swtq_pkg::ACT_REMOVE: begin
			pos = -1;
			for (int i = 0; i < sleepers.size(); i++) begin
				if (pos < 0 && sleepers[i].id == id)
					pos = i;
			end
			if (pos < 0)
				rep.status = swtq_pkg::ST_NOTFOUND;
			else
				sleepers.delete(pos);
		end
		default: begin
		end
		endcase
		// report the head, all zero when nothing sleeps
		if (sleepers.size() > 0) begin
			rep.head_valid = 1'b1;
			rep.head_id = sleepers[0].id;
			rep.head_sec = sleepers[0].sec;
			rep.head_usec = sleepers[0].usec;
			rep.head_time_us = swtq_pkg::TIME_W'(64'(sleepers[0].sec) * USEC_PER_SEC
				+ 64'(sleepers[0].usec));
		end
		rep.entry_count = swtq_pkg::CNT_W'(sleepers.size());
		return rep;
	endfunction

	// retire finished reports first, then predict the item taken at this edge
	always @(posedge clk) begin
		head_report_t want;
		if (arst_n) begin
			if (done) begin
				if (due_reports.size() == 0) begin
					log_mismatch("result with no item outstanding");
				end else begin
					want = due_reports[0];
					due_reports.delete(0);
					check_field("status", status, want.status);
					check_field("head_valid", head_valid, want.head_valid);
					check_field("head_id", head_id, want.head_id);
					check_field("head_sec", head_sec, want.head_sec);
					check_field("head_usec", head_usec, want.head_usec);
					check_field("head_time_us", head_time_us, want.head_time_us);
					check_field("entry_count", entry_count, want.entry_count);
				end
			end
			if (start && !busy)
				due_reports.insert(due_reports.size(),
					apply_action(action, entry_id, wake_sec, wake_usec));
		end
		waiting <= due_reports.size();
	end

endmodule

// ===== sim/testbench.sv =====
module testbench;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int MODE_FILL  = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIXED = 2;
	localparam int ITEM_TARGET = 1500;
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_GAP     = 50;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic [1:0]                    action = swtq_pkg::ACT_ADD;
	logic [swtq_pkg::ID_BITS-1:0]  entry_id = '0;
	logic [swtq_pkg::SEC_W-1:0]    wake_sec = '0;
	logic [swtq_pkg::USEC_W-1:0]   wake_usec = '0;
	logic                          busy;
	logic                          done;
	logic [1:0]                    status;
	logic                          head_valid;
	logic [swtq_pkg::ID_BITS-1:0]  head_id;
	logic [swtq_pkg::SEC_W-1:0]    head_sec;
	logic [swtq_pkg::USEC_W-1:0]   head_usec;
	logic [swtq_pkg::TIME_W-1:0]   head_time_us;
	logic [swtq_pkg::CNT_W-1:0]    entry_count;
	int                            fail_count;
	int                            waiting;
	int                            idle_pct = 11;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sorted_wakeup_timer_queue u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.entry_id     (entry_id),
		.wake_sec     (wake_sec),
		.wake_usec    (wake_usec),
		.done         (done),
		.status       (status),
		.head_valid   (head_valid),
		.head_id      (head_id),
		.head_sec     (head_sec),
		.head_usec    (head_usec),
		.head_time_us (head_time_us),
		.entry_count  (entry_count)
	);

	wakeup_queue_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.entry_id     (entry_id),
		.wake_sec     (wake_sec),
		.wake_usec    (wake_usec),
		.done         (done),
		.status       (status),
		.head_valid   (head_valid),
		.head_id      (head_id),
		.head_sec     (head_sec),
		.head_usec    (head_usec),
		.head_time_us (head_time_us),
		.entry_count  (entry_count),
		.fail_count   (fail_count),
		.waiting      (waiting)
	);

	// end the run when neither channel moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				quiet = 0;
			else
				quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// hold one item until the block takes it, then idle at random
	task automatic issue(logic [1:0] act, logic [swtq_pkg::ID_BITS-1:0] id,
			logic [swtq_pkg::SEC_W-1:0] sec, logic [swtq_pkg::USEC_W-1:0] usec);
		int gap;
		start <= 1'b1;
		action <= act;
		entry_id <= id;
		wake_sec <= sec;
		wake_usec <= usec;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		int sent;
		int mode;
		int round_left;
		int r;
		logic [1:0]                   act;
		logic [swtq_pkg::ID_BITS-1:0] id;
		logic [swtq_pkg::SEC_W-1:0]   sec;
		logic [swtq_pkg::USEC_W-1:0]  usec;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-queue cases, field extremes, ties, removes, ignored code
		issue(swtq_pkg::ACT_POP, 10'd0, 32'd0, 20'd0);
		issue(swtq_pkg::ACT_REMOVE, 10'd3, 32'd0, 20'd0);
		issue(ACT_UNUSED, 10'd0, 32'd0, 20'd0);
		issue(swtq_pkg::ACT_ADD, 10'd0, 32'd0, 20'd0);
		issue(swtq_pkg::ACT_ADD, 10'h3FF, 32'hFFFF_FFFF, 20'hF_FFFF);
		issue(swtq_pkg::ACT_ADD, 10'd5, 32'd100, 20'd999999);
		issue(swtq_pkg::ACT_ADD, 10'd6, 32'd100, 20'd999999);
		issue(swtq_pkg::ACT_ADD, 10'd7, 32'd100, 20'd0);
		issue(swtq_pkg::ACT_ADD, 10'd8, 32'd0, 20'd0);
		issue(swtq_pkg::ACT_ADD, 10'd9, 32'hFFFF_FFFF, 20'd999999);
		issue(swtq_pkg::ACT_ADD, 10'd10, 32'd99, 20'd1000000);
		issue(swtq_pkg::ACT_REMOVE, 10'd6, 32'd0, 20'd0);
		issue(swtq_pkg::ACT_REMOVE, 10'h3FF, 32'd0, 20'd0);
		issue(swtq_pkg::ACT_REMOVE, 10'd555, 32'd0, 20'd0);
		issue(ACT_UNUSED, 10'h2AA, 32'hAAAA_AAAA, 20'hA_AAAA);
		issue(swtq_pkg::ACT_ADD, 10'd7, 32'd50, 20'd1);
		issue(swtq_pkg::ACT_REMOVE, 10'd7, 32'd0, 20'd0);
		issue(swtq_pkg::ACT_POP, 10'd0, 32'd0, 20'd0);
		issue(swtq_pkg::ACT_REMOVE, 10'd8, 32'd0, 20'd0);
		issue(swtq_pkg::ACT_POP, 10'd0, 32'd0, 20'd0);
		issue(swtq_pkg::ACT_POP, 10'd0, 32'd0, 20'd0);
		issue(swtq_pkg::ACT_POP, 10'd0, 32'd0, 20'd0);
		issue(swtq_pkg::ACT_POP, 10'd0, 32'd0, 20'd0);
		issue(swtq_pkg::ACT_POP, 10'd0, 32'd0, 20'd0);

		// random rounds: filling runs favour adds, draining runs favour pops and removes
		sent = 0;
		round_left = 0;
		mode = MODE_FILL;
		while (sent < ITEM_TARGET) begin
			idle_pct = (sent < ITEM_TARGET / 3) ? 11 : (sent < 2 * ITEM_TARGET / 3) ? 68 : 0;
			if (round_left == 0) begin
				mode = $urandom_range(MODE_MIXED);
				round_left = $urandom_range(120, 40);
			end
			round_left--;

			r = $urandom_range(99);
			case (mode)
			MODE_FILL:  act = (r < 80) ? swtq_pkg::ACT_ADD : (r < 88) ? swtq_pkg::ACT_POP :
				(r < 97) ? swtq_pkg::ACT_REMOVE : ACT_UNUSED;
			MODE_DRAIN: act = (r < 20) ? swtq_pkg::ACT_ADD : (r < 60) ? swtq_pkg::ACT_POP :
				(r < 97) ? swtq_pkg::ACT_REMOVE : ACT_UNUSED;
			default:    act = (r < 45) ? swtq_pkg::ACT_ADD : (r < 70) ? swtq_pkg::ACT_POP :
				(r < 97) ? swtq_pkg::ACT_REMOVE : ACT_UNUSED;
			endcase

			// narrow ids so removes hit, narrow times so ties are common
			id = ($urandom_range(99) < 70) ? swtq_pkg::ID_BITS'($urandom_range(15))
				: swtq_pkg::ID_BITS'($urandom_range(1023));
			r = $urandom_range(99);
			sec = (r < 40) ? swtq_pkg::SEC_W'($urandom_range(3)) :
				(r < 70) ? swtq_pkg::SEC_W'($urandom_range(1000)) :
				(r < 95) ? swtq_pkg::SEC_W'($urandom()) :
				($urandom_range(1) ? 32'hFFFF_FFFF : 32'd0);
			r = $urandom_range(99);
			usec = (r < 40) ? swtq_pkg::USEC_W'($urandom_range(2)) :
				(r < 85) ? swtq_pkg::USEC_W'($urandom_range(999999)) :
				swtq_pkg::USEC_W'($urandom_range(1048575));

			issue(act, id, sec, usec);
			if (act != ACT_UNUSED)
				sent++;
		end

		// drain: wait for every report, then a tail for stray results
		start <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sorted_wakeup_timer_queue.f =====
src/swtq_pkg.sv
src/swtq_ram.sv
src/sorted_wakeup_timer_queue.sv
sim/wakeup_queue_checker.sv
sim/testbench.sv
